// File: rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that a condition implies another in the same cycle.
`define CBS_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Assert that a condition implies another in the following cycle.
`define CBS_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: rtl/cbs_pkg.sv
// Shared types and constants of the cubic B-spline sampler.
package cbs_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int COEF_W      = 20;
    localparam int ACC_W       = 56;
    localparam int PROD_W      = COEF_W + 33;
    // Reciprocal of 6 for the position rounding, exact below 2**21
    localparam int RECIP_SH    = 22;
    localparam logic [19:0] RECIP_K = 20'd699051;
    // Offset of six times half the output range
    localparam int POS_OFS     = 196608;

    localparam logic [1:0] REG_SAMPLES = 2'd0;
    localparam logic [1:0] REG_T_STEP  = 2'd1;
    localparam logic [1:0] REG_SPACING = 2'd2;

    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] d;
        logic signed [COEF_W-1:0] bd;
        logic signed [COEF_W-1:0] cd;
    } coef_t;

    typedef struct packed {
        coef_t [2:0] axis;
        logic [6:0]  n;
        logic [15:0] t_step;
        logic [6:0]  spacing;
    } job_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic avail;
    } qctl_t;

endpackage

// File: rtl/cubic_bspline_sampler_top.sv
// Top level of the cubic B-spline sampler.
// Usage:
//   s_* channel takes one control point per beat (x, y, z, signed Q8.8).
//   cfg_* channel writes samples_per_segment (0), t_step (1), tangent_spacing (2);
//   write only while the block is idle.
//   From the fourth point on each point closes a segment and the m_* channel
//   delivers samples_per_segment beats (at most 64): position, tangent
//   direction on every tangent_spacing-th sample (tuser), index, tlast on the
//   final sample of the segment.
// Sequence:
//   Each sample steps through t, t^2 and t^3, then the phases of each axis
//   on the multiplier shared by the three axes, then hands the beat to the
//   output register.
//   Two segments can wait in the job queue, so points keep flowing while
//   the back end works; s_tready drops when the queue is full.
// Reset: window, count and queue clear, registers return to 16, 4096, 4.
// Stall: a low m_tready keeps the output beat stable; the back end computes the next sample, then waits.
module cubic_bspline_sampler_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // point_x, point_y, point_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, sample_index
    output logic         m_tuser,   // dir_valid
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    cbs_pkg::job_t  push_job, head;
    cbs_pkg::qctl_t ctl;
    logic           push, pop;

    cbs_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .q_full   (ctl.full),
        .push     (push),
        .push_job (push_job)
    );

    cbs_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_job(push_job),
        .pop     (pop),
        .ctl     (ctl),
        .head    (head)
    );

    cbs_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .head    (head),
        .pop     (pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

// File: rtl/cbs_front.sv
// Front end: config registers, point window and segment coefficient setup.
module cbs_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [47:0]   s_tdata,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    input  logic          q_full,
    output logic          push,
    output cbs_pkg::job_t push_job
);

    logic [6:0]         spp_reg;
    logic [15:0]        tstep_reg;
    logic [6:0]         spacing_reg;
    logic signed [15:0] win_reg [0:8];
    logic [1:0]         seen_reg;
    logic               accept;
    logic [6:0]         n_eff;
    logic signed [15:0] pt [0:2];

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;

    assign pt[0] = s_tdata[15:0];
    assign pt[1] = s_tdata[31:16];
    assign pt[2] = s_tdata[47:32];

    // Clamp the sample count to the supported maximum
    assign n_eff = (spp_reg > 7'(cbs_pkg::MAX_SAMPLES)) ? 7'(cbs_pkg::MAX_SAMPLES) : spp_reg;

    // Form basis coefficients for each axis
    always_comb
    begin
        logic signed [cbs_pkg::COEF_W-1:0] q0, q1, q2, q3;
        push_job = '0;
        for (int c = 0; c < 3; c++)
        begin
            q0 = cbs_pkg::COEF_W'(win_reg[c]);
            q1 = cbs_pkg::COEF_W'(win_reg[3+c]);
            q2 = cbs_pkg::COEF_W'(win_reg[6+c]);
            q3 = cbs_pkg::COEF_W'(pt[c]);
            push_job.axis[c].a  = cbs_pkg::COEF_W'(-q0 + 3*q1 - 3*q2 + q3);
            push_job.axis[c].b  = cbs_pkg::COEF_W'(3*q0 - 6*q1 + 3*q2);
            push_job.axis[c].c  = cbs_pkg::COEF_W'(-3*q0 + 3*q2);
            push_job.axis[c].d  = cbs_pkg::COEF_W'(q0 + 4*q1 + q2);
            push_job.axis[c].bd = cbs_pkg::COEF_W'(2*q0 - 4*q1 + 2*q2);
            push_job.axis[c].cd = q2 - q0;
        end
        push_job.n       = n_eff;
        push_job.t_step  = tstep_reg;
        push_job.spacing = spacing_reg;
    end

    assign push = accept && (seen_reg == 2'd3) && (n_eff != 7'd0);

    // Take config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spp_reg     <= 7'd16;
            tstep_reg   <= 16'd4096;
            spacing_reg <= 7'd4;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cbs_pkg::REG_SAMPLES: spp_reg     <= cfg_data[6:0];
                cbs_pkg::REG_T_STEP:  tstep_reg   <= cfg_data;
                cbs_pkg::REG_SPACING: spacing_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Shift the window on every accepted point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 2'd0;
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else if (accept)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= win_reg[i+3];
            for (int c = 0; c < 3; c++)
                win_reg[6+c] <= pt[c];
            if (seen_reg != 2'd3)
                seen_reg <= seen_reg + 2'd1;
        end
    end

endmodule

// File: rtl/cbs_queue.sv
// Two-entry segment job queue between front and back.
module cbs_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cbs_pkg::job_t  push_job,
    input  logic           pop,
    output cbs_pkg::qctl_t ctl,
    output cbs_pkg::job_t  head
);

    cbs_pkg::job_t mem_reg [0:1];
    logic          wr_reg, rd_reg;
    logic [1:0]    cnt_reg;

    assign head      = mem_reg[rd_reg];
    assign ctl.push  = push;
    assign ctl.pop   = pop;
    assign ctl.full  = (cnt_reg == 2'd2);
    assign ctl.avail = (cnt_reg != 2'd0);

    // Store pushed jobs
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_job;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_reg <= !wr_reg;
            if (pop)
                rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// File: rtl/cbs_back.sv
// Back end: per-sample evaluation with a multiplier shared by the axes, and output register.
module cbs_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  cbs_pkg::qctl_t ctl,
    input  cbs_pkg::job_t  head,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [103:0]   m_tdata,
    output logic           m_tuser,
    output logic           m_tlast
);

    typedef enum logic [4:0]
    {
        ST_IDLE  = 5'b00001,
        ST_PARAM = 5'b00010,
        ST_SQR   = 5'b00100,
        ST_CUBE  = 5'b01000,
        ST_AXIS  = 5'b10000
    } state_t;

    state_t             state_reg;
    cbs_pkg::job_t      job_reg;
    logic [5:0]         k_reg;
    logic [6:0]         tcnt_reg;
    logic [21:0]        acc_reg;
    logic [15:0]        u_reg;
    logic [31:0]        t2_reg, t3_reg;
    logic               tg_reg;
    logic [1:0]         axis_reg;
    logic [2:0]         ph_reg;
    logic               emit_reg;
    logic signed [cbs_pkg::ACC_W-1:0] accp_reg, accd_reg;
    logic signed [23:0] mp_reg;
    logic [38:0]        recip_reg;
    logic [1:0]         sat_reg;
    logic [15:0]        pos_reg [0:2];
    logic [15:0]        dir_reg [0:2];
    logic               out_valid_reg, out_user_reg, out_last_reg;
    logic [103:0]       out_data_reg;

    cbs_pkg::coef_t     co;
    logic signed [cbs_pkg::COEF_W-1:0] opa;
    logic [31:0]        opb;
    logic signed [cbs_pkg::PROD_W-1:0] prod;
    logic signed [cbs_pkg::ACC_W-1:0]  prod_x, pos_sum, dir_sum;
    logic signed [22:0] dq;
    logic [15:0]        dsat;
    logic [18:0]        xofs;
    logic [47:0]        cube;
    logic               last_k, out_free, load_beat;

    assign co     = job_reg.axis[axis_reg];
    assign last_k = ({1'b0, k_reg} == job_reg.n - 7'd1);
    assign out_free = !out_valid_reg || m_tready;
    assign load_beat = (state_reg == ST_IDLE) && emit_reg && out_free;
    assign pop    = (state_reg == ST_IDLE) && !emit_reg && ctl.avail;

    // Select multiplier operands by phase
    always_comb
    begin
        case (ph_reg)
            3'd0:    begin opa = co.a;  opb = t3_reg;          end
            3'd1:    begin opa = co.b;  opb = t2_reg;          end
            3'd2:    begin opa = co.c;  opb = {16'd0, u_reg};  end
            3'd3:    begin opa = co.a;  opb = t2_reg;          end
            default: begin opa = co.bd; opb = {16'd0, u_reg};  end
        endcase
    end

    assign prod    = opa * $signed({1'b0, opb});
    assign prod_x  = cbs_pkg::ACC_W'(prod);
    assign pos_sum = accp_reg + ((cbs_pkg::ACC_W'(co.d) + 56'sd3) <<< 32);
    assign dir_sum = accd_reg + ((cbs_pkg::ACC_W'(co.cd) + 56'sd1) <<< 32);
    assign dq      = dir_sum[55:33];
    assign dsat    = (dq > 23'sd32767) ? 16'h7FFF :
                     (dq < -23'sd32768) ? 16'h8000 : dq[15:0];
    assign xofs    = 19'(mp_reg + 24'(cbs_pkg::POS_OFS));
    assign cube    = t2_reg * u_reg;

    // Present the output register
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // Hold the output beat until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_beat)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // Sequence one sample at a time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            emit_reg      <= 1'b0;
            k_reg         <= '0;
            tcnt_reg      <= '0;
            acc_reg       <= '0;
            axis_reg      <= '0;
            ph_reg        <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (emit_reg)
                    begin
                        // Wait for the output slot, then step to the next sample unless this was the last
                        if (out_free)
                        begin
                            emit_reg      <= 1'b0;
                            if (!last_k)
                            begin
                                k_reg     <= k_reg + 6'd1;
                                tcnt_reg  <= (tcnt_reg + 7'd1 == job_reg.spacing) ? 7'd0
                                             : tcnt_reg + 7'd1;
                                acc_reg   <= acc_reg + 22'(job_reg.t_step);
                                state_reg <= ST_PARAM;
                            end
                        end
                    end
                    else if (ctl.avail)
                    begin
                        k_reg     <= '0;
                        tcnt_reg  <= '0;
                        acc_reg   <= '0;
                        state_reg <= ST_PARAM;
                    end
                end
                ST_PARAM: state_reg <= ST_SQR;
                ST_SQR:   state_reg <= ST_CUBE;
                ST_CUBE:
                begin
                    axis_reg  <= '0;
                    ph_reg    <= '0;
                    state_reg <= ST_AXIS;
                end
                ST_AXIS:
                begin
                    ph_reg <= ph_reg + 3'd1;
                    if (ph_reg == 3'd7)
                    begin
                        if (axis_reg == 2'd2)
                        begin
                            emit_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        else
                            axis_reg <= axis_reg + 2'd1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= head;
        if (state_reg == ST_PARAM)
        begin
            u_reg  <= (acc_reg > 22'd65535) ? 16'hFFFF : acc_reg[15:0];
            tg_reg <= (job_reg.spacing != 7'd0) && (tcnt_reg == 7'd0);
        end
        if (state_reg == ST_SQR)
            t2_reg <= u_reg * u_reg;
        if (state_reg == ST_CUBE)
            t3_reg <= cube[47:16];
        if (state_reg == ST_AXIS)
        begin
            case (ph_reg)
                3'd0: accp_reg <= prod_x;
                3'd1: accp_reg <= accp_reg + prod_x;
                3'd2: accp_reg <= accp_reg + (prod_x <<< 16);
                3'd3: accd_reg <= prod_x;
                3'd4: accd_reg <= accd_reg + (prod_x <<< 16);
                3'd5:
                begin
                    mp_reg             <= pos_sum[55:32];
                    dir_reg[axis_reg]  <= tg_reg ? dsat : 16'd0;
                end
                3'd6:
                begin
                    sat_reg   <= {mp_reg >= 24'(cbs_pkg::POS_OFS),
                                  mp_reg < -24'(cbs_pkg::POS_OFS)};
                    recip_reg <= xofs * cbs_pkg::RECIP_K;
                end
                default:
                begin
                    pos_reg[axis_reg] <= sat_reg[1] ? 16'h7FFF :
                                         sat_reg[0] ? 16'h8000 :
                                         recip_reg[cbs_pkg::RECIP_SH+15:cbs_pkg::RECIP_SH]
                                         ^ 16'h8000;
                end
            endcase
        end
        // Load the output beat
        if (load_beat)
        begin
            out_data_reg <= {2'b00, k_reg, dir_reg[2], dir_reg[1], dir_reg[0],
                             pos_reg[2], pos_reg[1], pos_reg[0]};
            out_user_reg <= tg_reg;
            out_last_reg <= last_k;
        end
    end

endmodule

// File: rtl/cbs_checker.sv
// Port-level checker for the cubic B-spline sampler, bound to the top level.
`include "assert_macros.svh"
module cbs_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata,
    input logic         m_tuser,
    input logic         m_tlast
);

    // Hold a stalled beat
    `CBS_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid, "output beat dropped while stalled")
    // Direction is zero on samples without a tangent
    `CBS_ASSERT_SAME(a_dir_zero, m_tvalid && !m_tuser, m_tdata[95:48] == 48'd0, "direction not zero")
    // A segment start follows a taken last beat
    `CBS_ASSERT_NEXT(a_restart, m_tvalid && m_tready && m_tlast,
        !m_tvalid || (m_tdata[101:96] == 6'd0), "segment did not restart at index zero")
    // Index advances by one inside a segment
    `CBS_ASSERT_NEXT(a_step, m_tvalid && m_tready && !m_tlast,
        !m_tvalid || (m_tdata[101:96] == $past(m_tdata[101:96]) + 6'd1), "index skipped")

endmodule

bind cubic_bspline_sampler_top cbs_checker u_cbs_checker (.*);
